>>> hw/rtl/assert_macros.svh
// assertion helpers, all sampled on clk and off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_IMPLY(label, ante, cons)

`endif

`endif

>>> hw/rtl/gea_pkg.sv
`default_nettype none

package gea_pkg;

  localparam int unsigned NODE_FIELD_W   = 6;
  localparam int unsigned NODE_FIELD_SPAN = 64;
  localparam int unsigned COST_W         = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned ROBOT_FIELD_W  = 4;
  localparam int unsigned COUNT_W        = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_WRITE_COST = 2'd0,
    FUNC_SET_START  = 2'd1,
    FUNC_ASSIGN     = 2'd2,
    FUNC_NEW_BATCH  = 2'd3
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic [NODE_FIELD_W-1:0]   source_node;
    logic [NODE_FIELD_W-1:0]   dest_node;
    logic [COST_W-1:0]         cost_value;
    logic [ROBOT_FIELD_W-1:0]  robot_index;
  } in_item_t;

  typedef struct packed {
    logic [ROBOT_FIELD_W-1:0]  chosen_robot;
    logic [TIME_W-1:0]         finish_time;
    logic [TIME_W-1:0]         makespan;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic wr_state;
    logic wr_start;
    logic clear_batch;
  } robot_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/gea_cost_mem.sv
`default_nettype none

module gea_cost_mem #(
  parameter int unsigned ADDR_W = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [gea_pkg::COST_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [gea_pkg::COST_W-1:0] rdata
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [gea_pkg::COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/gea_robot_state.sv
`default_nettype none

module gea_robot_state #(
  parameter int unsigned ROBOT_MAX = 16,
  parameter int unsigned NODE_W    = 6,
  parameter int unsigned IDX_W     = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gea_pkg::robot_ctl_t        ctl,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic [NODE_W-1:0]          wr_end,
  input  logic [gea_pkg::TIME_W-1:0] wr_busy,
  input  logic [NODE_W-1:0]          start_node,
  input  logic [IDX_W-1:0]           rd_idx,
  output logic [NODE_W-1:0]          rd_end,
  output logic [gea_pkg::TIME_W-1:0] rd_busy
);

  typedef struct packed {
    logic [NODE_W-1:0]          end_node;
    logic [gea_pkg::TIME_W-1:0] busy;
  } entry_t;

  entry_t             mem [ROBOT_MAX];
  logic [ROBOT_MAX-1:0] live;
  logic [NODE_W-1:0]  start [ROBOT_MAX];

  entry_t            mem_wdata;
  logic              mem_we;
  entry_t            rd_q;
  logic              live_q;
  logic [NODE_W-1:0] start_q;

  // an idle robot's entry is materialized before its start node changes
  assign mem_we = ctl.wr_state || (ctl.wr_start && !live[wr_idx]);

  always_comb begin
    if (ctl.wr_state) begin
      mem_wdata = {wr_end, wr_busy};
    end else begin
      mem_wdata = {start[wr_idx], {gea_pkg::TIME_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= mem_wdata;
    end
    rd_q    <= mem[rd_idx];
    live_q  <= live[rd_idx];
    start_q <= start[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= '0;
      start <= '{default: '0};
    end else begin
      if (ctl.clear_batch) begin
        live <= '0;
      end else if (mem_we) begin
        live[wr_idx] <= 1'b1;
      end
      if (ctl.wr_start) begin
        start[wr_idx] <= start_node;
      end
    end
  end

  assign rd_end  = live_q ? rd_q.end_node : start_q;
  assign rd_busy = live_q ? rd_q.busy : '0;

endmodule

`default_nettype wire

>>> hw/rtl/greedy_earliest_finish_assigner_top.sv
// channel  direction  payload               transfer when
// cfg      in         cfg_wdata (robots)    cfg_we
// in       in         in_item (in_item_t)   in_valid && in_ready
// out      out        out_item (out_item_t) out_valid && out_ready
//
// an assignment scans the active robots with one cost table read per robot
// through the single read port of the cost memory
// rst is synchronous; the cost table holds no reset value
// a finished result waits in the output register; the next item is taken
// meanwhile, and an assignment holds in its last step while that register is full
`default_nettype none
`include "assert_macros.svh"

module greedy_earliest_finish_assigner_top #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned ROBOT_MAX  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gea_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gea_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gea_pkg::out_item_t          out_item
);

  localparam int unsigned NW    = $clog2(NODE_COUNT);
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned RW    = (ROBOT_MAX > 1) ? $clog2(ROBOT_MAX) : 1;
  localparam int unsigned RCW   = $clog2(ROBOT_MAX + 1);
  localparam int unsigned CMPW  = RCW + gea_pkg::COUNT_W;
  localparam int unsigned RAW_W = gea_pkg::TIME_W + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t                        state;
  logic [gea_pkg::COUNT_W-1:0]   robot_count;
  logic [RCW-1:0]                n_q;
  logic [RCW-1:0]                ri;
  logic [NW-1:0]                 src_q;
  logic [NW-1:0]                 dst_q;
  logic [gea_pkg::COST_W-1:0]    deliv;
  logic                          deliv_pend;
  logic                          v1, v2, v3;
  logic [RW-1:0]                 idx1, idx2, idx3;
  logic [gea_pkg::TIME_W-1:0]    busy2;
  logic [RAW_W-1:0]              raw3;
  logic                          have;
  logic [RW-1:0]                 best_idx;
  logic [gea_pkg::TIME_W-1:0]    best_fin;
  logic                          best_sat;
  logic [gea_pkg::TIME_W-1:0]    makespan;
  logic                          out_valid_q;
  gea_pkg::out_item_t            out_q;

  logic [NW-1:0]                 wrap_tab [gea_pkg::NODE_FIELD_SPAN];
  logic [NW-1:0]                 src_w;
  logic [NW-1:0]                 dst_w;
  logic                          accept;
  logic [CMPW-1:0]               cnt_ext;
  logic [CMPW-1:0]               n_clamp;
  logic [RCW-1:0]                n_next;
  logic                          issue;
  logic [NW-1:0]                 rob_end;
  logic [gea_pkg::TIME_W-1:0]    rob_busy;
  logic [AW-1:0]                 cost_raddr;
  logic [gea_pkg::COST_W-1:0]    cost_rdata;
  logic                          cost_we;
  logic                          sat3;
  logic [gea_pkg::TIME_W-1:0]    fin3;
  logic                          take;
  logic                          scan_done;
  logic                          slot_free;
  logic                          upd;
  logic [gea_pkg::TIME_W-1:0]    mk_next;
  logic                          start_ok;
  gea_pkg::robot_ctl_t           rctl;
  logic [RW-1:0]                 rwr_idx;

  // node numbers wrap modulo the node count
  for (genvar g = 0; g < gea_pkg::NODE_FIELD_SPAN; g++) begin : g_wrap
    localparam int unsigned WRAPPED = g % NODE_COUNT;
    assign wrap_tab[g] = NW'(WRAPPED);
  end

  assign src_w    = wrap_tab[in_item.source_node];
  assign dst_w    = wrap_tab[in_item.dest_node];
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign cnt_ext = CMPW'(robot_count);
  always_comb begin
    if (cnt_ext == '0) begin
      n_clamp = CMPW'(1);
    end else if (cnt_ext > CMPW'(ROBOT_MAX)) begin
      n_clamp = CMPW'(ROBOT_MAX);
    end else begin
      n_clamp = cnt_ext;
    end
  end
  assign n_next = n_clamp[RCW-1:0];

  assign issue      = (state == ST_SCAN) && (ri < n_q);
  assign cost_raddr = (state == ST_IDLE) ? {src_w, dst_w} : {rob_end, src_q};
  assign cost_we    = accept && (in_item.func == gea_pkg::FUNC_WRITE_COST);

  assign sat3 = raw3 > RAW_W'(gea_pkg::TIME_MAX);
  assign fin3 = sat3 ? gea_pkg::TIME_MAX : raw3[gea_pkg::TIME_W-1:0];
  assign take = v3 && (!have || (fin3 < best_fin));

  assign scan_done = (state == ST_SCAN) && (ri == n_q) && !v1 && !v2 && !v3;
  assign slot_free = !out_valid_q || out_ready;
  assign upd       = (state == ST_UPDATE) && slot_free;
  assign mk_next   = (best_fin > makespan) ? best_fin : makespan;

  assign start_ok = CMPW'(in_item.robot_index) < CMPW'(ROBOT_MAX);

  assign rctl.wr_state    = upd;
  assign rctl.wr_start    = accept && (in_item.func == gea_pkg::FUNC_SET_START) && start_ok;
  assign rctl.clear_batch = accept && (in_item.func == gea_pkg::FUNC_NEW_BATCH);
  assign rwr_idx          = upd ? best_idx : RW'(in_item.robot_index);

  gea_cost_mem #(
    .ADDR_W (AW)
  ) u_cost_mem (
    .clk   (clk),
    .we    (cost_we),
    .waddr ({src_w, dst_w}),
    .wdata (in_item.cost_value),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  gea_robot_state #(
    .ROBOT_MAX (ROBOT_MAX),
    .NODE_W    (NW),
    .IDX_W     (RW)
  ) u_robot_state (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rctl),
    .wr_idx     (rwr_idx),
    .wr_end     (dst_q),
    .wr_busy    (best_fin),
    .start_node (dst_w),
    .rd_idx     (ri[RW-1:0]),
    .rd_end     (rob_end),
    .rd_busy    (rob_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      robot_count <= gea_pkg::COUNT_W'(1);
      n_q         <= RCW'(1);
      ri          <= '0;
      deliv_pend  <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      have        <= 1'b0;
      makespan    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        robot_count <= cfg_wdata;
      end
      if (out_ready && !upd) begin
        out_valid_q <= 1'b0;
      end

      // scan pipeline: robot read, cost read, sum, compare
      v1    <= issue;
      idx1  <= ri[RW-1:0];
      v2    <= v1;
      idx2  <= idx1;
      busy2 <= rob_busy;
      v3    <= v2;
      idx3  <= idx2;
      raw3  <= RAW_W'(busy2) + RAW_W'(cost_rdata) + RAW_W'(deliv);

      if (deliv_pend) begin
        deliv      <= cost_rdata;
        deliv_pend <= 1'b0;
      end
      if (take) begin
        have     <= 1'b1;
        best_idx <= idx3;
        best_fin <= fin3;
        best_sat <= sat3;
      end
      if (issue) begin
        ri <= ri + RCW'(1);
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_item.func)
              gea_pkg::FUNC_NEW_BATCH: begin
                makespan <= '0;
              end
              gea_pkg::FUNC_ASSIGN: begin
                src_q      <= src_w;
                dst_q      <= dst_w;
                n_q        <= n_next;
                ri         <= '0;
                have       <= 1'b0;
                deliv_pend <= 1'b1;
                state      <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (slot_free) begin
            makespan           <= mk_next;
            out_valid_q        <= 1'b1;
            out_q.chosen_robot <= gea_pkg::ROBOT_FIELD_W'(best_idx);
            out_q.finish_time  <= best_fin;
            out_q.makespan     <= mk_next;
            out_q.saturated    <= best_sat;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_q;
  assign out_item  = out_q;

  `ASSERT_IMPLY(a_ready_empty, in_ready, !v1 && !v2 && !v3)
  `ASSERT_IMPLY(a_scan_bound, state == ST_SCAN, ri <= n_q)
  `ASSERT_CLK(a_take_have, v3 |=> have)
  `ASSERT_IMPLY(a_out_order, out_valid_q, out_q.makespan >= out_q.finish_time)
  `ASSERT_IMPLY(a_sat_clip, out_valid_q && out_q.saturated, out_q.finish_time == gea_pkg::TIME_MAX)

endmodule

`default_nettype wire

>>> bench/greedy_earliest_finish_assigner_top_tb.sv
module greedy_earliest_finish_assigner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROBOTS = 16;
  localparam int unsigned SLOTS = gea_pkg::NODE_FIELD_SPAN * gea_pkg::NODE_FIELD_SPAN;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned SEGMENT_ITEMS = 85;
  localparam int unsigned LOOP_STEPS = 12;
  localparam logic [gea_pkg::TIME_W+1:0] TIME_CEIL = {2'b00, gea_pkg::TIME_MAX};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gea_pkg::COUNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  gea_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gea_pkg::out_item_t out_item;

  always #2 clk = ~clk;

  greedy_earliest_finish_assigner_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  // fleet state as the block should hold it
  logic [gea_pkg::COST_W-1:0] travel_cost [SLOTS];
  bit cost_written [SLOTS];
  logic [gea_pkg::NODE_FIELD_W-1:0] home_node [ROBOTS];
  logic [gea_pkg::NODE_FIELD_W-1:0] last_node [ROBOTS];
  logic [gea_pkg::TIME_W-1:0] busy_time [ROBOTS];
  logic [gea_pkg::TIME_W-1:0] batch_span;
  logic [gea_pkg::COUNT_W-1:0] robot_setting;

  gea_pkg::out_item_t pending_assignments [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned ceiling_hits = 0;
  int unsigned cycle_count = 0;

  logic [gea_pkg::NODE_FIELD_W-1:0] hot_nodes [6] = '{6'd0, 6'd63, 6'd21, 6'd42, 6'd7, 6'd56};
  logic [gea_pkg::COUNT_W-1:0] robot_plan [9] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd9,
                                                  5'd17, 5'd16, 5'd5};

  function automatic logic [11:0] slot_of(input logic [gea_pkg::NODE_FIELD_W-1:0] from, to);
    return {from, to};
  endfunction

  function automatic int unsigned active_robots();
    if (robot_setting == '0) return 1;
    if (32'(robot_setting) > ROBOTS) return ROBOTS;
    return 32'(robot_setting);
  endfunction

  function automatic gea_pkg::in_item_t noise();
    logic [$bits(gea_pkg::in_item_t)-1:0] raw_bits;
    raw_bits = {2'($urandom), 32'($urandom)};
    return gea_pkg::in_item_t'(raw_bits);
  endfunction

  function automatic logic [gea_pkg::NODE_FIELD_W-1:0] pick_node();
    if ($urandom_range(99) < 70) return hot_nodes[3'($urandom_range(5))];
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [gea_pkg::COST_W-1:0] pick_cost();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // applies each item to the fleet; an assignment takes the greedy earliest-finish choice over the active robots
  task automatic apply_to_fleet(input gea_pkg::in_item_t it);
    logic [gea_pkg::TIME_W+1:0] raw;
    logic [gea_pkg::TIME_W+1:0] best_raw;
    logic [gea_pkg::TIME_W-1:0] fin;
    logic [gea_pkg::TIME_W-1:0] best_fin;
    int unsigned best;
    gea_pkg::out_item_t res;
    case (it.func)
      gea_pkg::FUNC_WRITE_COST: begin
        travel_cost[slot_of(it.source_node, it.dest_node)] = it.cost_value;
        cost_written[slot_of(it.source_node, it.dest_node)] = 1'b1;
      end
      gea_pkg::FUNC_SET_START: begin
        home_node[it.robot_index] = it.dest_node;
      end
      gea_pkg::FUNC_NEW_BATCH: begin
        for (int r = 0; r < ROBOTS; r++) begin
          busy_time[r] = '0;
          last_node[r] = home_node[r];
        end
        batch_span = '0;
      end
      gea_pkg::FUNC_ASSIGN: begin
        best = 0;
        best_fin = '0;
        best_raw = '0;
        for (int r = 0; r < active_robots(); r++) begin
          raw = {2'b00, busy_time[r]}
              + 34'(travel_cost[slot_of(last_node[r], it.source_node)])
              + 34'(travel_cost[slot_of(it.source_node, it.dest_node)]);
          fin = (raw > TIME_CEIL) ? gea_pkg::TIME_MAX : raw[gea_pkg::TIME_W-1:0];
          if (r == 0 || fin < best_fin) begin
            best = r;
            best_fin = fin;
            best_raw = raw;
          end
        end
        busy_time[best] = best_fin;
        last_node[best] = it.dest_node;
        if (best_fin > batch_span) batch_span = best_fin;
        res.chosen_robot = 4'(best);
        res.finish_time = best_fin;
        res.makespan = batch_span;
        res.saturated = (best_raw > TIME_CEIL);
        pending_assignments.insert(pending_assignments.size(), res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input gea_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_to_fleet(it);
    items_sent++;
  endtask

  task automatic write_cost(input logic [gea_pkg::NODE_FIELD_W-1:0] from, to,
                            input logic [gea_pkg::COST_W-1:0] value);
    gea_pkg::in_item_t it;
    it = noise();
    it.func = gea_pkg::FUNC_WRITE_COST;
    it.source_node = from;
    it.dest_node = to;
    it.cost_value = value;
    send_item(it);
  endtask

  task automatic set_start(input logic [gea_pkg::ROBOT_FIELD_W-1:0] robot,
                           input logic [gea_pkg::NODE_FIELD_W-1:0] node);
    gea_pkg::in_item_t it;
    it = noise();
    it.func = gea_pkg::FUNC_SET_START;
    it.robot_index = robot;
    it.dest_node = node;
    send_item(it);
  endtask

  task automatic new_batch();
    gea_pkg::in_item_t it;
    it = noise();
    it.func = gea_pkg::FUNC_NEW_BATCH;
    send_item(it);
  endtask

  // fills any cost entry the scan would read before sending the task
  task automatic assign_task(input logic [gea_pkg::NODE_FIELD_W-1:0] src, dst);
    gea_pkg::in_item_t it;
    for (int r = 0; r < active_robots(); r++) begin
      if (!cost_written[slot_of(last_node[r], src)]) write_cost(last_node[r], src, pick_cost());
    end
    if (!cost_written[slot_of(src, dst)]) write_cost(src, dst, pick_cost());
    it = noise();
    it.func = gea_pkg::FUNC_ASSIGN;
    it.source_node = src;
    it.dest_node = dst;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_robots(input logic [gea_pkg::COUNT_W-1:0] count);
    drain();
    cfg_wdata <= count;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    robot_setting = count;
  endtask

  task automatic compare_field(input string field, input logic [gea_pkg::TIME_W-1:0] got, want);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    gea_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_assignments.size() == 0) begin
        err_count++;
        $display("%0t ns: result with none expected, expected nothing, actual %p",
                 $time, out_item);
      end else begin
        want = pending_assignments.pop_front();
        results_checked++;
        if (want.saturated) ceiling_hits++;
        compare_field("chosen_robot", 32'(out_item.chosen_robot), 32'(want.chosen_robot));
        compare_field("finish_time", out_item.finish_time, want.finish_time);
        compare_field("makespan", out_item.makespan, want.makespan);
        compare_field("saturated", 32'(out_item.saturated), 32'(want.saturated));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // robot count left at its reset value of one
  task automatic test_single_robot();
    write_cost(6'd0, 6'd0, 16'h0000);
    assign_task(6'd0, 6'd0);
    write_cost(6'd0, 6'd63, 16'hFFFF);
    assign_task(6'd0, 6'd63);
    write_cost(6'd63, 6'd0, 16'hFFFF);
    assign_task(6'd63, 6'd0);
    new_batch();
    assign_task(6'd0, 6'd63);
  endtask

  task automatic test_tie_break();
    set_robots(5'd16);
    new_batch();
    write_cost(6'd0, 6'd21, 16'd3);
    repeat (4) assign_task(6'd0, 6'd21);
  endtask

  task automatic test_start_moved_mid_batch();
    set_start(4'd15, 6'd63);
    set_start(4'd0, 6'd42);
    repeat (2) assign_task(6'd21, 6'd0);
    new_batch();
    repeat (2) assign_task(6'd63, 6'd42);
  endtask

  task automatic test_robot_count_extremes();
    set_robots(5'd0);
    new_batch();
    repeat (2) assign_task(6'd7, 6'd56);
    set_robots(5'd31);
    repeat (2) assign_task(6'd56, 6'd7);
    set_robots(5'd17);
    assign_task(6'd7, 6'd7);
  endtask

  task automatic random_op();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) assign_task(pick_node(), pick_node());
    else if (pick < 72) write_cost(pick_node(), pick_node(), pick_cost());
    else if (pick < 88) set_start(4'($urandom_range(15)), pick_node());
    else new_batch();
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct, receiver_pct,
                                     input int unsigned plan_base);
    int unsigned stop_at;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int seg = 0; seg < 3; seg++) begin
      set_robots(robot_plan[plan_base + seg]);
      new_batch();
      stop_at = items_sent + SEGMENT_ITEMS;
      while (items_sent < stop_at) random_op();
    end
  endtask

  // one robot on the most expensive loop, then a second robot joins
  task automatic test_costly_loop();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_robots(5'd1);
    set_start(4'd0, 6'd0);
    set_start(4'd1, 6'd0);
    write_cost(6'd0, 6'd0, 16'hFFFF);
    new_batch();
    repeat (LOOP_STEPS) assign_task(6'd0, 6'd0);
    set_robots(5'd2);
    repeat (3) assign_task(6'd0, 6'd0);
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      travel_cost[s] = '0;
      cost_written[s] = 1'b0;
    end
    for (int r = 0; r < ROBOTS; r++) begin
      home_node[r] = '0;
      last_node[r] = '0;
      busy_time[r] = '0;
    end
    batch_span = '0;
    robot_setting = 5'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_robot();
    test_tie_break();
    test_start_moved_mid_batch();
    test_robot_count_extremes();
    test_random_traffic(31, 55, 0);
    test_random_traffic(55, 31, 3);
    test_random_traffic(0, 0, 6);
    test_costly_loop();
    drain();
    $display("sent %0d transfers over robot counts 0 to 31, checked %0d assignments",
             items_sent, results_checked);
    $display("%0d assignments reached the busy time ceiling", ceiling_hits);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
